@@ design/pwmt_pkg.sv @@
// shared types and constants for the physical window mapping table
`default_nettype none

package pwmt_pkg;

  // one stored mapping: physical start, virtual start, length in bytes
  typedef struct packed {
    logic [31:0] phys;
    logic [31:0] virt;
    logic [31:0] length;
  } slot_t;

  // result status codes
  localparam logic [2:0] StExist    = 3'd0;
  localparam logic [2:0] StNew      = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StNoSlot   = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  // command codes
  localparam logic CmdMap    = 1'b0;
  localparam logic CmdLookup = 1'b1;

  // configuration register indexes
  localparam logic [1:0] RegWindowBase   = 2'd0;
  localparam logic [1:0] RegWindowSize   = 2'd1;
  localparam logic [1:0] RegIdentLimit   = 2'd2;
  localparam logic [1:0] RegKernVirtBase = 2'd3;

  // page geometry and attribute bits
  localparam int unsigned PageShift = 12;
  localparam logic [32:0] PageRound = 33'd4095;
  localparam logic [4:0]  AttrBase  = 5'h03;
  localparam logic [4:0]  AttrMask  = 5'h18;

endpackage

`default_nettype wire

@@ design/pwmt_slot_mem.sv @@
// slot storage: one write port, one registered read port
`default_nettype none

module pwmt_slot_mem #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AddrW-1:0]     wr_addr_i,
  input  wire pwmt_pkg::slot_t      wr_data_i,
  input  wire logic [AddrW-1:0]     rd_addr_i,
  output pwmt_pkg::slot_t           rd_data_o
);

  pwmt_pkg::slot_t mem_q [Depth];
  pwmt_pkg::slot_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ design/physical_window_mapping_table.sv @@
// top level: mapping table sequencer, configuration and result register
`default_nettype none

// Each beat on the input is a map request or a lookup of a physical address
// and gives exactly one result beat. Slots fill in order and are never freed,
// so a fill count marks the valid ones and no clearing pass is needed after
// reset. An identity hit goes from acceptance straight to the response state.
// Otherwise the filled slots are read one per cycle through the single read
// port of the slot memory, stopping at the first hit. A lookup miss passes
// through the miss state to the response state, and a map miss through the
// miss state and, if a slot is free, the allocation state. The next beat is
// taken in the cycle after the result is loaded, so the sequencer holds only
// one item at a time. A stalled result holds the sequencer in its response
// state. Writing window_base restarts the virtual allocator.
module physical_window_mapping_table #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  // input beats
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        in_cmd_i,
  input  wire logic [31:0] in_phys_addr_i,
  input  wire logic [31:0] in_range_bytes_i,
  input  wire logic [7:0]  in_map_flags_i,
  // result beats
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       out_status_o,
  output logic [31:0]      out_virt_addr_o,
  output logic [19:0]      out_first_phys_page_o,
  output logic [19:0]      out_first_virt_page_o,
  output logic [20:0]      out_page_count_o,
  output logic [4:0]       out_page_attr_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam logic [CntW-1:0] SlotsFull = CntW'(SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MISS  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [32:0]     next_free_q, next_free_d;
  logic [31:0]     win_base_q, win_size_q, ident_limit_q, kvirt_base_q;
  logic            out_valid_q, out_valid_d;

  // latched item
  logic            cmd_q;
  logic [31:0]     phys_q, range_q;
  logic [7:0]      flags_q;
  logic [20:0]     pages_q, pages_d;

  // pending result
  logic [2:0]      res_status_q, res_status_d;
  logic [31:0]     res_virt_q, res_virt_d;
  logic [19:0]     res_fpp_q, res_fpp_d;
  logic [19:0]     res_fvp_q, res_fvp_d;
  logic [20:0]     res_pages_q, res_pages_d;
  logic [4:0]      res_attr_q, res_attr_d;

  logic            in_fire;
  logic            out_free;
  logic [IdxW-1:0] rd_addr;
  pwmt_pkg::slot_t rd_slot;
  logic            wr_en;
  pwmt_pkg::slot_t wr_slot;
  logic [CntW-1:0] idx_next;
  logic            slot_hit;
  logic [32:0]     slot_end;
  logic [32:0]     round_sum;
  logic [32:0]     total_bytes;
  logic [33:0]     alloc_end;
  logic [33:0]     win_end;
  logic [31:0]     alloc_virt;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // slot memory
  pwmt_slot_mem #(
    .Depth (SLOTS)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_q[IdxW-1:0]),
    .wr_data_i (wr_slot),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_slot)
  );

  // scan address: slot 0 on accept, then the slot after the one compared
  assign idx_next = CntW'(idx_q) + CntW'(1);
  assign rd_addr  = (state_q == S_IDLE) ? '0 : idx_next[IdxW-1:0];

  // range check of the slot read last cycle
  assign slot_end = {1'b0, rd_slot.phys} + {1'b0, rd_slot.length};
  assign slot_hit = (phys_q >= rd_slot.phys) && ({1'b0, phys_q} < slot_end);

  // page rounding and window check
  assign round_sum   = {1'b0, range_q} + {21'd0, phys_q[11:0]} + pwmt_pkg::PageRound;
  assign total_bytes = {pages_q, 12'd0};
  assign alloc_end   = {1'b0, next_free_q} + {1'b0, total_bytes};
  assign win_end     = {2'b00, win_base_q} + {2'b00, win_size_q};
  assign alloc_virt  = next_free_q[31:0] + {20'd0, phys_q[11:0]};

  assign wr_slot.phys   = phys_q;
  assign wr_slot.virt   = alloc_virt;
  assign wr_slot.length = range_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    fill_d       = fill_q;
    next_free_d  = next_free_q;
    out_valid_d  = out_valid_q;
    pages_d      = pages_q;
    res_status_d = res_status_q;
    res_virt_d   = res_virt_q;
    res_fpp_d    = res_fpp_q;
    res_fvp_d    = res_fvp_q;
    res_pages_d  = res_pages_q;
    res_attr_d   = res_attr_q;
    wr_en        = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_fpp_d   = '0;
          res_fvp_d   = '0;
          res_pages_d = '0;
          res_attr_d  = '0;
          res_virt_d  = '0;
          idx_d       = '0;
          if (in_phys_addr_i < ident_limit_q) begin
            res_status_d = pwmt_pkg::StExist;
            res_virt_d   = in_phys_addr_i + kvirt_base_q;
            state_d      = S_RESP;
          end else if (fill_q == '0) begin
            state_d = S_MISS;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (slot_hit) begin
          res_status_d = pwmt_pkg::StExist;
          res_virt_d   = rd_slot.virt + (phys_q - rd_slot.phys);
          state_d      = S_RESP;
        end else if (idx_next == fill_q) begin
          state_d = S_MISS;
        end else begin
          idx_d = idx_next[IdxW-1:0];
        end
      end
      S_MISS: begin
        if (cmd_q == pwmt_pkg::CmdLookup) begin
          res_status_d = pwmt_pkg::StNotFound;
          state_d      = S_RESP;
        end else if (fill_q == SlotsFull) begin
          res_status_d = pwmt_pkg::StNoSlot;
          state_d      = S_RESP;
        end else begin
          pages_d = round_sum[32:pwmt_pkg::PageShift];
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (alloc_end > win_end) begin
          res_status_d = pwmt_pkg::StFull;
        end else begin
          wr_en        = 1'b1;
          fill_d       = fill_q + CntW'(1);
          next_free_d  = alloc_end[32:0];
          res_status_d = pwmt_pkg::StNew;
          res_virt_d   = alloc_virt;
          res_fpp_d    = phys_q[31:12];
          res_fvp_d    = next_free_q[31:12];
          res_pages_d  = pages_q;
          res_attr_d   = pwmt_pkg::AttrBase | (flags_q[4:0] & pwmt_pkg::AttrMask);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a window base write restarts the allocator
    if (cfg_we_i && cfg_idx_i == pwmt_pkg::RegWindowBase) begin
      next_free_d = {1'b0, cfg_wdata_i};
    end
  end

  // control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      fill_q        <= '0;
      next_free_q   <= '0;
      out_valid_q   <= 1'b0;
      win_base_q    <= '0;
      win_size_q    <= '0;
      ident_limit_q <= '0;
      kvirt_base_q  <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      next_free_q <= next_free_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pwmt_pkg::RegWindowBase:   win_base_q    <= cfg_wdata_i;
          pwmt_pkg::RegWindowSize:   win_size_q    <= cfg_wdata_i;
          pwmt_pkg::RegIdentLimit:   ident_limit_q <= cfg_wdata_i;
          pwmt_pkg::RegKernVirtBase: kvirt_base_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= in_cmd_i;
      phys_q  <= in_phys_addr_i;
      range_q <= in_range_bytes_i;
      flags_q <= in_map_flags_i;
    end
    pages_q      <= pages_d;
    res_status_q <= res_status_d;
    res_virt_q   <= res_virt_d;
    res_fpp_q    <= res_fpp_d;
    res_fvp_q    <= res_fvp_d;
    res_pages_q  <= res_pages_d;
    res_attr_q   <= res_attr_d;
    if (state_q == S_RESP && out_free) begin
      out_status_o          <= res_status_q;
      out_virt_addr_o       <= res_virt_q;
      out_first_phys_page_o <= res_fpp_q;
      out_first_virt_page_o <= res_fvp_q;
      out_page_count_o      <= res_pages_q;
      out_page_attr_o       <= res_attr_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // fill count stays within the table
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= SlotsFull)
    else $error("fill count beyond table depth");

  // scan only visits filled slots
  a_scan_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> CntW'(idx_q) < fill_q)
    else $error("scan index past filled slots");

  // a slot is taken only by a successful map
  a_fill_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != $past(fill_q) |-> ($past(state_q) == S_ALLOC && res_status_q == pwmt_pkg::StNew))
    else $error("slot taken without new mapping");

  // a result beat is launched only from the response state
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result beat without response state");

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("accepted beat dropped");

endmodule

`default_nettype wire

@@ verif/pwmt_checker.sv @@
// checker for the mapping table: predicts every result beat and compares it
`timescale 1ns / 1ps

module pwmt_checker #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        in_cmd_i,
  input  logic [31:0] in_phys_addr_i,
  input  logic [31:0] in_range_bytes_i,
  input  logic [7:0]  in_map_flags_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  out_status_i,
  input  logic [31:0] out_virt_addr_i,
  input  logic [19:0] out_first_phys_page_i,
  input  logic [19:0] out_first_virt_page_i,
  input  logic [20:0] out_page_count_i,
  input  logic [4:0]  out_page_attr_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] virt;
    logic [19:0] phys_page;
    logic [19:0] virt_page;
    logic [20:0] pages;
    logic [4:0]  attr;
  } map_result_t;

  // shadow copy of the registers, the slot table and the allocator
  logic [31:0] win_base, win_size, ident_limit, kern_base;
  logic        slot_used [SLOTS];
  logic [31:0] slot_pa [SLOTS];
  logic [31:0] slot_va [SLOTS];
  logic [31:0] slot_len [SLOTS];
  logic [32:0] alloc_ptr;

  map_result_t expected_q [$];

  // translate or map one request, updating the shadow table
  function automatic map_result_t translate_or_map(logic cmd, logic [31:0] pa,
                                                   logic [31:0] len, logic [7:0] flags);
    map_result_t res;
    logic        hit;
    int          free_idx;
    logic [11:0] offs;
    logic [63:0] pages, span, va_full, top_sum;
    logic [32:0] vbase;
    res = '0;
    res.status = pwmt_pkg::StExist;
    hit = 1'b0;
    free_idx = -1;

    // identity region first, then the first containing slot
    if (pa < ident_limit) begin
      hit = 1'b1;
      res.virt = pa + kern_base;
    end
    for (int i = 0; i < SLOTS && !hit; i++) begin
      if (slot_used[i] && pa >= slot_pa[i] &&
          {1'b0, pa} < {1'b0, slot_pa[i]} + {1'b0, slot_len[i]}) begin
        hit = 1'b1;
        res.virt = slot_va[i] + (pa - slot_pa[i]);
      end
    end
    if (hit) return res;
    if (cmd == pwmt_pkg::CmdLookup) begin
      res.status = pwmt_pkg::StNotFound;
      return res;
    end

    for (int i = 0; i < SLOTS && free_idx < 0; i++)
      if (!slot_used[i]) free_idx = i;
    if (free_idx < 0) begin
      res.status = pwmt_pkg::StNoSlot;
      return res;
    end

    // round to whole pages and check the window for room
    offs = pa[11:0];
    pages = (64'(len) + 64'(offs) + 64'd4095) >> pwmt_pkg::PageShift;
    span = pages << pwmt_pkg::PageShift;
    vbase = alloc_ptr;
    if (64'(vbase) + span > 64'(win_base) + 64'(win_size)) begin
      res.status = pwmt_pkg::StFull;
      return res;
    end

    va_full = 64'(vbase) + 64'(offs);
    top_sum = 64'(vbase) + span;
    slot_used[free_idx] = 1'b1;
    slot_pa[free_idx] = pa;
    slot_va[free_idx] = va_full[31:0];
    slot_len[free_idx] = len;
    alloc_ptr = top_sum[32:0];

    res.status = pwmt_pkg::StNew;
    res.virt = va_full[31:0];
    res.phys_page = pa[31:12];
    res.virt_page = vbase[31:12];
    res.pages = pages[20:0];
    res.attr = pwmt_pkg::AttrBase | (flags[4:0] & pwmt_pkg::AttrMask);
    return res;
  endfunction

  // watch config writes, input beats and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t want, got;
    if (!rst_ni) begin
      win_base = '0;
      win_size = '0;
      ident_limit = '0;
      kern_base = '0;
      alloc_ptr = '0;
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      expected_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pwmt_pkg::RegWindowBase: begin
            win_base = cfg_wdata_i;
            alloc_ptr = {1'b0, cfg_wdata_i};
          end
          pwmt_pkg::RegWindowSize:   win_size = cfg_wdata_i;
          pwmt_pkg::RegIdentLimit:   ident_limit = cfg_wdata_i;
          pwmt_pkg::RegKernVirtBase: kern_base = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(translate_or_map(in_cmd_i, in_phys_addr_i,
                                              in_range_bytes_i, in_map_flags_i));
        pending_o++;
      end

      if (out_valid_i && !out_stall_i) begin
        got = {out_status_i, out_virt_addr_i, out_first_phys_page_i,
               out_first_virt_page_i, out_page_count_i, out_page_attr_i};
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: result beat with nothing expected: status %0d virt %h",
                     $time, got.status, got.virt);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          pending_o--;
          if (got !== want) begin
            if (fail_count_o < 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected status %0d virt %h ppage %h vpage %h pages %0d attr %h",
                       want.status, want.virt, want.phys_page, want.virt_page,
                       want.pages, want.attr);
              $display("  actual   status %0d virt %h ppage %h vpage %h pages %0d attr %h",
                       got.status, got.virt, got.phys_page, got.virt_page,
                       got.pages, got.attr);
            end
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

@@ verif/tb_physical_window_mapping_table.sv @@
// testbench top for the mapping table: stimulus, register phases and verdict
`timescale 1ns / 1ps

module tb_physical_window_mapping_table;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned SETTLE_CYCLES = SLOTS + 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = pwmt_pkg::RegWindowBase;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = pwmt_pkg::CmdMap;
  logic [31:0] in_phys_addr = '0;
  logic [31:0] in_range_bytes = '0;
  logic [7:0]  in_map_flags = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_virt_addr;
  logic [19:0] out_first_phys_page;
  logic [19:0] out_first_virt_page;
  logic [20:0] out_page_count;
  logic [4:0]  out_page_attr;
  int          fail_count;
  int          pending;

  // identity limit last written, and map requests sent so far
  logic [31:0] cur_limit = '0;
  logic [31:0] known_pa [$];
  logic [31:0] known_len [$];

  physical_window_mapping_table #(.SLOTS(SLOTS)) dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .in_cmd_i              (in_cmd),
    .in_phys_addr_i        (in_phys_addr),
    .in_range_bytes_i      (in_range_bytes),
    .in_map_flags_i        (in_map_flags),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .out_status_o          (out_status),
    .out_virt_addr_o       (out_virt_addr),
    .out_first_phys_page_o (out_first_phys_page),
    .out_first_virt_page_o (out_first_virt_page),
    .out_page_count_o      (out_page_count),
    .out_page_attr_o       (out_page_attr)
  );

  pwmt_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .in_cmd_i              (in_cmd),
    .in_phys_addr_i        (in_phys_addr),
    .in_range_bytes_i      (in_range_bytes),
    .in_map_flags_i        (in_map_flags),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .out_status_i          (out_status),
    .out_virt_addr_i       (out_virt_addr),
    .out_first_phys_page_i (out_first_phys_page),
    .out_first_virt_page_i (out_first_virt_page),
    .out_page_count_i      (out_page_count),
    .out_page_attr_i       (out_page_attr),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  always #5 clk = ~clk;

  // receiver stall pattern: free, random, heavy or alternating, switched now and then
  int unsigned rx_mode = 0;
  int unsigned rx_mode_cycles = 0;
  always @(posedge clk) begin
    if (rx_mode_cycles == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_cycles = $urandom_range(50, 600);
    end else begin
      rx_mode_cycles--;
    end
    case (rx_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  // present one beat and hold it until accepted
  task automatic send_beat(input logic cmd, input logic [31:0] pa,
                           input logic [31:0] len, input logic [7:0] flags);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_phys_addr <= pa;
    in_range_bytes <= len;
    in_map_flags <= flags;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_for(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every expected result beat is back, then let the block settle
  task automatic drain_all();
    idle_for(1);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_window(input logic [31:0] base, input logic [31:0] size,
                                input logic [31:0] lim, input logic [31:0] kbase);
    set_reg(pwmt_pkg::RegWindowBase, base);
    set_reg(pwmt_pkg::RegWindowSize, size);
    set_reg(pwmt_pkg::RegIdentLimit, lim);
    set_reg(pwmt_pkg::RegKernVirtBase, kbase);
    cur_limit = lim;
  endtask

  // random register setting, extremes included
  task automatic random_window();
    logic [31:0] base, size, lim, kbase;
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = 32'hFFFF_F000;
      2: base = $urandom & 32'hFFFF_F000;
      default: base = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: size = '0;
      1: size = $urandom_range(0, 32'h0010_0000);
      2: size = $urandom;
      default: size = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 4))
      0: lim = '0;
      1, 2: lim = $urandom_range(0, 32'h0100_0000);
      3: lim = $urandom;
      default: lim = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 3))
      0: kbase = '0;
      1: kbase = 32'hFFFF_FFFF;
      default: kbase = $urandom;
    endcase
    program_window(base, size, lim, kbase);
  endtask

  // one random request, aimed near earlier maps and the identity limit
  task automatic random_beat();
    logic        cmd;
    logic [31:0] pa, len;
    logic [7:0]  flags;
    int unsigned pick, k, lsel;
    cmd = ($urandom_range(0, 99) < 55) ? pwmt_pkg::CmdLookup : pwmt_pkg::CmdMap;
    flags = $urandom;
    lsel = $urandom_range(0, 99);
    if (lsel < 5) len = '0;
    else if (lsel < 10) len = 32'hFFFF_FFFF;
    else if (lsel < 15) len = $urandom;
    else len = $urandom_range(1, 32'h4000);

    pick = $urandom_range(0, 99);
    if (known_pa.size() > 0 && pick < 40) begin
      k = $urandom_range(0, (known_pa.size() < 80 ? known_pa.size() : 80) - 1);
      case ($urandom_range(0, 3))
        0: pa = known_pa[k];
        1: pa = (known_len[k] == 0) ? known_pa[k] : known_pa[k] + ($urandom % known_len[k]);
        2: pa = known_pa[k] + known_len[k];
        default: pa = known_pa[k] - 1;
      endcase
    end else if (pick < 55 && cur_limit != 0) begin
      pa = cur_limit - $urandom_range(0, 1);
    end else if (pick < 58) begin
      pa = '0;
    end else if (pick < 60) begin
      pa = 32'hFFFF_FFFF;
    end else begin
      pa = $urandom;
    end

    // most maps land outside the identity region, some page aligned
    if (cmd == pwmt_pkg::CmdMap) begin
      if (pa < cur_limit && $urandom_range(0, 3) != 0)
        pa = $urandom_range(32'hFFFF_FFFF, cur_limit);
      if ($urandom_range(0, 3) == 0) pa[11:0] = '0;
      known_pa.push_back(pa);
      known_len.push_back(len);
    end
    send_beat(cmd, pa, len, flags);
  endtask

  // random beats in bursts with gaps, and an occasional full drain
  task automatic random_run(input int unsigned count);
    int unsigned burst_left;
    burst_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 99) == 0) drain_all();
        else idle_for($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(1, 6);
      end
      burst_left--;
      random_beat();
    end
    drain_all();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: empty window, no identity region
    send_beat(pwmt_pkg::CmdLookup, 32'h0000_0000, 32'h0, 8'h00);
    send_beat(pwmt_pkg::CmdMap,    32'h0000_1000, 32'h0, 8'h00);  // zero length still maps
    send_beat(pwmt_pkg::CmdLookup, 32'h0000_1000, 32'h0, 8'h00);  // zero length never hits
    send_beat(pwmt_pkg::CmdMap,    32'h0000_2001, 32'h1, 8'h00);  // no room
    send_beat(pwmt_pkg::CmdMap,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    drain_all();

    // identity region, new maps, hits and misses at range edges
    program_window(32'h4000_0000, 32'h0010_0000, 32'h0010_0000, 32'hC000_0000);
    send_beat(pwmt_pkg::CmdLookup, 32'h0000_0000, 32'h0, 8'h00);
    send_beat(pwmt_pkg::CmdLookup, 32'h000F_FFFF, 32'h0, 8'h00);
    send_beat(pwmt_pkg::CmdLookup, 32'h0010_0000, 32'h0, 8'h00);
    send_beat(pwmt_pkg::CmdMap,    32'h0000_8000, 32'h10, 8'hFF);  // identity hit on map
    send_beat(pwmt_pkg::CmdMap,    32'h1234_5678, 32'h2000, 8'hFF);
    send_beat(pwmt_pkg::CmdLookup, 32'h1234_7677, 32'h0, 8'h00);
    send_beat(pwmt_pkg::CmdLookup, 32'h1234_7678, 32'h0, 8'h00);
    send_beat(pwmt_pkg::CmdMap,    32'h1234_6000, 32'h4, 8'h10);   // already mapped
    send_beat(pwmt_pkg::CmdMap,    32'h2000_0000, 32'h1000, 8'h08);
    send_beat(pwmt_pkg::CmdMap,    32'h3000_0FFF, 32'h1, 8'h10);
    send_beat(pwmt_pkg::CmdMap,    32'h5000_0000, 32'h0020_0000, 8'h00);
    send_beat(pwmt_pkg::CmdMap,    32'h6000_0000, 32'h0, 8'h00);
    drain_all();

    // identity translation wrapping to zero
    set_reg(pwmt_pkg::RegIdentLimit, 32'hFFFF_FFFF);
    set_reg(pwmt_pkg::RegKernVirtBase, 32'hFFFF_FFFF);
    cur_limit = 32'hFFFF_FFFF;
    send_beat(pwmt_pkg::CmdLookup, 32'h0000_0001, 32'h0, 8'h00);
    send_beat(pwmt_pkg::CmdMap,    32'hFFFF_FFFE, 32'h100, 8'hFF);
    send_beat(pwmt_pkg::CmdLookup, 32'hFFFF_FFFF, 32'h0, 8'h00);
    drain_all();

    // window crossing 4 GiB, slot translation wrapping to zero
    program_window(32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_beat(pwmt_pkg::CmdMap,    32'h7000_0000, 32'h2000, 8'h18);
    send_beat(pwmt_pkg::CmdLookup, 32'h7000_1000, 32'h0, 8'h00);
    send_beat(pwmt_pkg::CmdMap,    32'h7100_0000, 32'h1000, 8'h00);
    drain_all();

    // rewriting the base restarts the allocator, slots stay
    set_reg(pwmt_pkg::RegWindowBase, 32'h4000_0000);
    send_beat(pwmt_pkg::CmdMap,    32'h7200_0000, 32'h1000, 8'h00);
    send_beat(pwmt_pkg::CmdLookup, 32'h1234_5678, 32'h0, 8'h00);
    drain_all();

    // random phases: a modest window first, then random settings
    program_window($urandom & 32'hFFFF_F000, 32'h0008_0000, 32'h0001_0000, $urandom);
    random_run(400);
    for (int p = 0; p < 4; p++) begin
      random_window();
      random_run(400);
    end

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
